@@ design/zbfw_pkg.sv @@
`timescale 1ns / 1ps
// zbfw_pkg: shared constants, codes and types of the z-buffer fragment writer
// no dependencies

package zbfw_pkg;

    localparam int FRAME_PIXELS = 131072;
    localparam int DEPTH_BITS   = 24;
    localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int COLOR_W      = 32;
    localparam int COORD_W      = 12;
    localparam int DIM_W        = 11;
    localparam int IDX_W        = 2 * DIM_W + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [DEPTH_BITS-1:0] MAX_DEPTH    = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic [COLOR_W-1:0]    OPAQUE_COLOR = 32'h0000_00ff;
    localparam logic [COLOR_W-1:0]    ALPHA_MASK   = 32'h0000_00ff;

    localparam logic [DIM_W-1:0]      WIDTH_RST = 11'd320;
    localparam logic [DIM_W-1:0]      HEIGHT_RST = 11'd240;
    localparam logic [DEPTH_BITS-1:0] NEAR_RST = '0;
    localparam logic [DEPTH_BITS-1:0] FAR_RST = {1'b0, {(DEPTH_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_OFFSCREEN,
        ST_RANGE,
        ST_ZFAIL
    } t_status;

    typedef enum logic [1:0] {
        CMD_REPLY,
        CMD_READ,
        CMD_CLEAR,
        CMD_WRITE
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_CLIP_EN,
        CFG_NEAR,
        CFG_FAR
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LOOK
    } t_bstate;

    typedef struct packed {
        t_cmd                          cmd;
        t_status                       status;
        logic [ADDR_W-1:0]             addr;
        logic signed [DEPTH_BITS-1:0]  depth;
        logic [COLOR_W-1:0]            color;
    } t_entry;

endpackage

@@ design/zbfw_in_if.sv @@
`timescale 1ns / 1ps
// zbfw_in_if: fragment channel, valid/ready with the fragment payload
// depends on zbfw_pkg

interface zbfw_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              op;
    logic signed [zbfw_pkg::COORD_W-1:0]     pixel_x;
    logic signed [zbfw_pkg::COORD_W-1:0]     pixel_y;
    logic signed [zbfw_pkg::DEPTH_BITS-1:0]  depth;
    logic [zbfw_pkg::COLOR_W-1:0]            frag_color;

    modport source (output valid, op, pixel_x, pixel_y, depth, frag_color, input ready);
    modport sink (input valid, op, pixel_x, pixel_y, depth, frag_color, output ready);
endinterface

@@ design/zbfw_out_if.sv @@
`timescale 1ns / 1ps
// zbfw_out_if: result channel, valid/ready with read color and status
// depends on zbfw_pkg

interface zbfw_out_if;
    logic                          valid;
    logic                          ready;
    logic [zbfw_pkg::COLOR_W-1:0]  read_color;
    logic [1:0]                    status;

    modport source (output valid, read_color, status, input ready);
    modport sink (input valid, read_color, status, output ready);
endinterface

@@ design/zbfw_ram.sv @@
`timescale 1ns / 1ps
// zbfw_ram: generic single write port, single read port ram with registered read
// no dependencies

module zbfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_waddr,
    input  logic [WIDTH-1:0]                                i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/zbfw_front.sv @@
`timescale 1ns / 1ps
// zbfw_front: configuration registers, fragment intake and classification
// depends on zbfw_pkg, zbfw_in_if

module zbfw_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [zbfw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [zbfw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_clearing,
    input  logic                                i_push_ready,
    output logic                                o_push_valid,
    output zbfw_pkg::t_entry                    o_push_entry,
    zbfw_in_if.sink                             i_frag
);
    logic [zbfw_pkg::DIM_W-1:0]              r_width;
    logic [zbfw_pkg::DIM_W-1:0]              r_height;
    logic                                    r_clip_en;
    logic signed [zbfw_pkg::DEPTH_BITS-1:0]  r_near;
    logic signed [zbfw_pkg::DEPTH_BITS-1:0]  r_far;

    logic [zbfw_pkg::DIM_W-1:0]  x_u;
    logic [zbfw_pkg::DIM_W-1:0]  y_u;
    logic [zbfw_pkg::IDX_W-1:0]  lin;
    logic                        onscreen;
    logic                        range_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= zbfw_pkg::WIDTH_RST;
            r_height  <= zbfw_pkg::HEIGHT_RST;
            r_clip_en <= 1'b0;
            r_near    <= zbfw_pkg::NEAR_RST;
            r_far     <= zbfw_pkg::FAR_RST;
        end else if (i_cfg_we) begin
            case (zbfw_pkg::t_cfg_idx'(i_cfg_idx))
                zbfw_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[zbfw_pkg::DIM_W-1:0];
                zbfw_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[zbfw_pkg::DIM_W-1:0];
                zbfw_pkg::CFG_CLIP_EN: r_clip_en <= i_cfg_data[0];
                zbfw_pkg::CFG_NEAR:    r_near    <= i_cfg_data[zbfw_pkg::DEPTH_BITS-1:0];
                zbfw_pkg::CFG_FAR:     r_far     <= i_cfg_data[zbfw_pkg::DEPTH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign x_u = i_frag.pixel_x[zbfw_pkg::DIM_W-1:0];
    assign y_u = i_frag.pixel_y[zbfw_pkg::DIM_W-1:0];
    assign lin = zbfw_pkg::IDX_W'(y_u) * zbfw_pkg::IDX_W'(r_width)
               + zbfw_pkg::IDX_W'(x_u);

    assign onscreen = !i_frag.pixel_x[zbfw_pkg::COORD_W-1]
                   && !i_frag.pixel_y[zbfw_pkg::COORD_W-1]
                   && (x_u < r_width) && (y_u < r_height)
                   && (lin < zbfw_pkg::IDX_W'(zbfw_pkg::FRAME_PIXELS));

    assign range_bad = r_clip_en && ((i_frag.depth <= r_near) || (i_frag.depth > r_far));

    always_comb begin
        o_push_entry.addr   = lin[zbfw_pkg::ADDR_W-1:0];
        o_push_entry.depth  = i_frag.depth;
        o_push_entry.color  = i_frag.frag_color | zbfw_pkg::ALPHA_MASK;
        o_push_entry.cmd    = zbfw_pkg::CMD_REPLY;
        o_push_entry.status = zbfw_pkg::ST_DONE;
        if (zbfw_pkg::t_op'(i_frag.op) == zbfw_pkg::OP_NOP) begin
            o_push_entry.cmd = zbfw_pkg::CMD_REPLY;
        end else if (!onscreen) begin
            o_push_entry.status = zbfw_pkg::ST_OFFSCREEN;
        end else begin
            case (zbfw_pkg::t_op'(i_frag.op))
                zbfw_pkg::OP_READ:  o_push_entry.cmd = zbfw_pkg::CMD_READ;
                zbfw_pkg::OP_CLEAR: o_push_entry.cmd = zbfw_pkg::CMD_CLEAR;
                zbfw_pkg::OP_WRITE: begin
                    if (range_bad) begin
                        o_push_entry.status = zbfw_pkg::ST_RANGE;
                    end else begin
                        o_push_entry.cmd = zbfw_pkg::CMD_WRITE;
                    end
                end
                default: o_push_entry.cmd = zbfw_pkg::CMD_REPLY;
            endcase
        end
    end

    assign i_frag.ready = i_push_ready && !i_clearing;
    assign o_push_valid = i_frag.valid && i_push_ready && !i_clearing;
endmodule

@@ design/zbfw_queue.sv @@
`timescale 1ns / 1ps
// zbfw_queue: short fifo of classified items between front and back
// depends on zbfw_pkg

module zbfw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  zbfw_pkg::t_entry  i_push_entry,
    output logic              o_pop_valid,
    input  logic              i_pop,
    output zbfw_pkg::t_entry  o_pop_entry
);
    localparam int QP_W = (zbfw_pkg::QUEUE_DEPTH > 1) ? $clog2(zbfw_pkg::QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(zbfw_pkg::QUEUE_DEPTH + 1);

    zbfw_pkg::t_entry  r_slot [zbfw_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wp;
    logic [QP_W-1:0]   r_rp;
    logic [QC_W-1:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QC_W'(zbfw_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_slot[r_rp];
    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QP_W'(zbfw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QP_W'(zbfw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ design/zbfw_back.sv @@
`timescale 1ns / 1ps
// zbfw_back: pixel store clearing pass, read-modify-write of depth and color, result register
// depends on zbfw_pkg, zbfw_out_if, zbfw_ram

module zbfw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  zbfw_pkg::t_entry  i_q_entry,
    output logic              o_q_pop,
    output logic              o_clearing,
    zbfw_out_if.source        o_result
);
    localparam logic [zbfw_pkg::ADDR_W-1:0] LAST_ADDR =
        zbfw_pkg::ADDR_W'(zbfw_pkg::FRAME_PIXELS - 1);

    zbfw_pkg::t_bstate                 r_state, n_state;
    logic [zbfw_pkg::ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    zbfw_pkg::t_entry                  r_cur, n_cur;
    logic                              r_out_valid, n_out_valid;
    logic [zbfw_pkg::COLOR_W-1:0]      r_out_color, n_out_color;
    zbfw_pkg::t_status                 r_out_status, n_out_status;

    logic                              ram_we;
    logic [zbfw_pkg::ADDR_W-1:0]       ram_waddr;
    logic [zbfw_pkg::DEPTH_BITS-1:0]   wd_depth;
    logic [zbfw_pkg::COLOR_W-1:0]      wd_color;
    logic [zbfw_pkg::DEPTH_BITS-1:0]   rd_depth;
    logic [zbfw_pkg::COLOR_W-1:0]      rd_color;
    logic                              take;

    zbfw_ram #(.WIDTH(zbfw_pkg::DEPTH_BITS), .DEPTH(zbfw_pkg::FRAME_PIXELS)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wd_depth),
        .i_raddr (i_q_entry.addr),
        .o_rdata (rd_depth)
    );

    zbfw_ram #(.WIDTH(zbfw_pkg::COLOR_W), .DEPTH(zbfw_pkg::FRAME_PIXELS)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wd_color),
        .i_raddr (i_q_entry.addr),
        .o_rdata (rd_color)
    );

    assign take = (r_state == zbfw_pkg::BS_IDLE) && i_q_valid
               && (!r_out_valid || o_result.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            zbfw_pkg::BS_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = zbfw_pkg::BS_IDLE;
                end
            end
            zbfw_pkg::BS_IDLE: begin
                if (take && ((i_q_entry.cmd == zbfw_pkg::CMD_READ)
                          || (i_q_entry.cmd == zbfw_pkg::CMD_WRITE))) begin
                    n_state = zbfw_pkg::BS_LOOK;
                end
            end
            zbfw_pkg::BS_LOOK: n_state = zbfw_pkg::BS_IDLE;
            default:           n_state = zbfw_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_cur.addr;
        wd_depth     = r_cur.depth;
        wd_color     = r_cur.color;
        n_clr_addr   = r_clr_addr;
        n_cur        = r_cur;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_color  = r_out_color;
        n_out_status = r_out_status;
        case (r_state)
            zbfw_pkg::BS_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                wd_depth   = zbfw_pkg::MAX_DEPTH;
                wd_color   = zbfw_pkg::OPAQUE_COLOR;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            zbfw_pkg::BS_IDLE: begin
                if (take) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_entry;
                    case (i_q_entry.cmd)
                        zbfw_pkg::CMD_REPLY: begin
                            n_out_valid  = 1'b1;
                            n_out_color  = '0;
                            n_out_status = i_q_entry.status;
                        end
                        zbfw_pkg::CMD_CLEAR: begin
                            ram_we       = 1'b1;
                            ram_waddr    = i_q_entry.addr;
                            wd_depth     = zbfw_pkg::MAX_DEPTH;
                            wd_color     = zbfw_pkg::OPAQUE_COLOR;
                            n_out_valid  = 1'b1;
                            n_out_color  = '0;
                            n_out_status = zbfw_pkg::ST_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            zbfw_pkg::BS_LOOK: begin
                n_out_valid = 1'b1;
                if (r_cur.cmd == zbfw_pkg::CMD_READ) begin
                    n_out_color  = rd_color;
                    n_out_status = zbfw_pkg::ST_DONE;
                end else if ($signed(rd_depth) > $signed(r_cur.depth)) begin
                    ram_we       = 1'b1;
                    n_out_color  = '0;
                    n_out_status = zbfw_pkg::ST_DONE;
                end else begin
                    n_out_color  = '0;
                    n_out_status = zbfw_pkg::ST_ZFAIL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= zbfw_pkg::BS_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_out_color  <= n_out_color;
        r_out_status <= n_out_status;
    end

    assign o_clearing          = (r_state == zbfw_pkg::BS_CLEAR);
    assign o_result.valid      = r_out_valid;
    assign o_result.read_color = r_out_color;
    assign o_result.status     = r_out_status;
endmodule

@@ design/zbuffer_fragment_write_top.sv @@
`timescale 1ns / 1ps
// channel   | dir | port       | payload
// fragment  | in  | i_frag     | op, pixel_x, pixel_y, depth, frag_color
// result    | out | o_result   | read_color, status
// config    | in  | i_cfg_*    | register index, write data
//
// one result per fragment, in order; a two-entry queue sits between intake and store
// reads and depth-tested writes go through ram read, then compare/write, in the back end
// clears, off-screen, range-rejected and unused-op items are answered from the idle state alone
// after reset a clearing pass writes all 131072 store entries; i_frag.ready stays low
// a stalled result holds in its output register while intake continues until the queue is full
// depends on zbfw_pkg, zbfw_in_if, zbfw_out_if, zbfw_front, zbfw_queue, zbfw_back

module zbuffer_fragment_write_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [zbfw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [zbfw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    zbfw_in_if.sink                          i_frag,
    zbfw_out_if.source                       o_result
);
    logic              push_valid;
    logic              push_ready;
    zbfw_pkg::t_entry  push_entry;
    logic              pop_valid;
    logic              pop;
    zbfw_pkg::t_entry  pop_entry;
    logic              clearing;

    zbfw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_clearing   (clearing),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_frag       (i_frag)
    );

    zbfw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_entry  (pop_entry)
    );

    zbfw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (pop_valid),
        .i_q_entry  (pop_entry),
        .o_q_pop    (pop),
        .o_clearing (clearing),
        .o_result   (o_result)
    );
endmodule

@@ design/zbfw_check.sv @@
`timescale 1ns / 1ps
// zbfw_check: port-level assertions for the z-buffer fragment writer, bound to the top level
// depends on zbfw_pkg, zbuffer_fragment_write_top

module zbfw_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [zbfw_pkg::COLOR_W-1:0]  i_out_color,
    input logic [1:0]                    i_out_status
);
    // no transfer right after reset, the clearing pass is running
    a_ready_low_after_reset: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n) |-> !i_in_ready)
        else $error("fragment ready high right after reset");

    // only a successful read carries a color
    a_color_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_color != '0)) |-> (i_out_status == zbfw_pkg::ST_DONE))
        else $error("nonzero read color with failure status");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_color) && $stable(i_out_status)))
        else $error("stalled result changed");
endmodule

bind zbuffer_fragment_write_top zbfw_check u_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_frag.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_color  (o_result.read_color),
    .i_out_status (o_result.status)
);

@@ test/zbfw_pixel_checker.sv @@
`timescale 1ns / 1ps
// zbfw_pixel_checker: watches the fragment, result and config ports of the z-buffer writer,
// predicts each result from its own depth/color stores and compares them in order
// depends on zbfw_pkg, zbfw_in_if, zbfw_out_if

module zbfw_pixel_checker
    import zbfw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    zbfw_in_if                     i_frag,
    zbfw_out_if                    i_result,
    output int                     o_errors,
    output int                     o_checked,
    output int                     o_pending
);

    typedef struct packed {
        t_op                          op;
        logic signed [COORD_W-1:0]    x;
        logic signed [COORD_W-1:0]    y;
        logic [COLOR_W-1:0]           read_color;
        t_status                      status;
    } t_pixel_reply;

    logic [DIM_W-1:0]              frame_w;
    logic [DIM_W-1:0]              frame_h;
    logic                          clip_on;
    logic signed [DEPTH_BITS-1:0]  near_z;
    logic signed [DEPTH_BITS-1:0]  far_z;

    logic signed [DEPTH_BITS-1:0]  depth_mem [FRAME_PIXELS];
    logic [COLOR_W-1:0]            color_mem [FRAME_PIXELS];

    t_pixel_reply replies_due [$];
    int errors = 0;
    int checked = 0;
    int pending_cnt = 0;

    assign o_errors  = errors;
    assign o_checked = checked;
    assign o_pending = pending_cnt;

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t zbfw check: %s", $time, what);
    endtask

    function automatic t_pixel_reply resolve_fragment(
        input t_op                          op,
        input logic signed [COORD_W-1:0]    px,
        input logic signed [COORD_W-1:0]    py,
        input logic signed [DEPTH_BITS-1:0] z,
        input logic [COLOR_W-1:0]           c
    );
        t_pixel_reply r;
        int xi;
        int yi;
        int pix;
        bit hit;
        r.op = op;
        r.x = px;
        r.y = py;
        r.read_color = '0;
        r.status = ST_DONE;
        xi = int'(px);
        yi = int'(py);
        pix = 0;
        hit = xi >= 0 && yi >= 0 && xi < int'(frame_w) && yi < int'(frame_h);
        if (hit) begin
            pix = yi * int'(frame_w) + xi;
            // frame bigger than the store
            if (pix >= FRAME_PIXELS) hit = 1'b0;
        end
        if (op == OP_NOP) begin
            r.status = ST_DONE;
        end else if (!hit) begin
            r.status = ST_OFFSCREEN;
        end else if (op == OP_READ) begin
            r.read_color = color_mem[pix];
        end else if (op == OP_CLEAR) begin
            depth_mem[pix] = MAX_DEPTH;
            color_mem[pix] = OPAQUE_COLOR;
        end else if (clip_on && (z <= near_z || z > far_z)) begin
            r.status = ST_RANGE;
        end else if (depth_mem[pix] > z) begin
            color_mem[pix] = c | ALPHA_MASK;
            depth_mem[pix] = z;
        end else begin
            r.status = ST_ZFAIL;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_reply want;
        logic [COLOR_W-1:0] got_color;
        logic [1:0] got_status;
        if (!i_rst_n) begin
            frame_w = WIDTH_RST;
            frame_h = HEIGHT_RST;
            clip_on = 1'b0;
            near_z = NEAR_RST;
            far_z = FAR_RST;
            for (int i = 0; i < FRAME_PIXELS; i++) begin
                depth_mem[i] = MAX_DEPTH;
                color_mem[i] = OPAQUE_COLOR;
            end
            replies_due.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got_color = i_result.read_color;
                got_status = i_result.status;
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("result with no fragment pending: color %08h status %0d",
                                              got_color, got_status));
                end else begin
                    want = replies_due.pop_front();
                    checked++;
                    if (got_color !== want.read_color) begin
                        report_mismatch($sformatf("op %0d (%0d,%0d): read_color %08h, predicted %08h",
                                                  want.op, want.x, want.y, got_color,
                                                  want.read_color));
                    end
                    if (got_status !== want.status) begin
                        report_mismatch($sformatf("op %0d (%0d,%0d): status %0d, predicted %0d",
                                                  want.op, want.x, want.y, got_status,
                                                  want.status));
                    end
                end
            end
            if (i_frag.valid && i_frag.ready) begin
                replies_due.insert(replies_due.size(),
                                   resolve_fragment(t_op'(i_frag.op), i_frag.pixel_x,
                                                    i_frag.pixel_y, i_frag.depth,
                                                    i_frag.frag_color));
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH:   frame_w = i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT:  frame_h = i_cfg_data[DIM_W-1:0];
                    CFG_CLIP_EN: clip_on = i_cfg_data[0];
                    CFG_NEAR:    near_z = i_cfg_data[DEPTH_BITS-1:0];
                    CFG_FAR:     far_z = i_cfg_data[DEPTH_BITS-1:0];
                    default: ;
                endcase
            end
        end
        pending_cnt = replies_due.size();
    end

endmodule

@@ test/zbuffer_fragment_write_top_test.sv @@
`timescale 1ns / 1ps
// zbuffer_fragment_write_top_test: drives fragments, frame settings and result stalls into the
// z-buffer writer; zbfw_pixel_checker predicts and compares, this module gives the verdict
// depends on zbfw_pkg, zbfw_in_if, zbfw_out_if, zbfw_pixel_checker, zbuffer_fragment_write_top

module zbuffer_fragment_write_top_test;
    import zbfw_pkg::*;

    // the clearing pass after reset runs with no transfer
    localparam int IDLE_LIMIT  = 4 * FRAME_PIXELS;
    localparam int HOLD_CYCLES = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;

    zbfw_in_if  frag_if ();
    zbfw_out_if result_if ();

    int errors;
    int checked;
    int pending;
    int quiet_cycles;
    int sent;
    int settings_used;
    bit send_gaps;
    bit take_stalls;

    logic [DIM_W-1:0]              cur_w;
    logic [DIM_W-1:0]              cur_h;
    logic signed [DEPTH_BITS-1:0]  cur_near;
    logic signed [DEPTH_BITS-1:0]  cur_far;

    zbuffer_fragment_write_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_frag     (frag_if),
        .o_result   (result_if)
    );

    zbfw_pixel_checker pixel_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_frag     (frag_if),
        .i_result   (result_if),
        .o_errors   (errors),
        .o_checked  (checked),
        .o_pending  (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(
        input logic [DIM_W-1:0]              w,
        input logic [DIM_W-1:0]              h,
        input logic                          clip,
        input logic signed [DEPTH_BITS-1:0]  near_b,
        input logic signed [DEPTH_BITS-1:0]  far_b
    );
        cfg_write(CFG_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_HEIGHT, CFG_DATA_W'(h));
        cfg_write(CFG_CLIP_EN, CFG_DATA_W'(clip));
        cfg_write(CFG_NEAR, near_b);
        cfg_write(CFG_FAR, far_b);
        cur_w = w;
        cur_h = h;
        cur_near = near_b;
        cur_far = far_b;
        settings_used++;
    endtask

    task automatic send_frag(
        input t_op                          op,
        input logic signed [COORD_W-1:0]    x,
        input logic signed [COORD_W-1:0]    y,
        input logic signed [DEPTH_BITS-1:0] z,
        input logic [COLOR_W-1:0]           c
    );
        int gap;
        gap = send_gaps ? $urandom_range(0, 12) : 0;
        @(negedge clk);
        if (gap > 0) begin
            frag_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frag_if.valid <= 1'b1;
        frag_if.op <= op;
        frag_if.pixel_x <= x;
        frag_if.pixel_y <= y;
        frag_if.depth <= z;
        frag_if.frag_color <= c;
        do @(posedge clk); while (!frag_if.ready);
        sent++;
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        @(negedge clk);
        frag_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (HOLD_CYCLES) @(negedge clk);
    endtask

    task automatic send_random(input int count);
        int n;
        int iter;
        int pick;
        int hx;
        int hy;
        t_op op;
        logic signed [COORD_W-1:0]    x;
        logic signed [COORD_W-1:0]    y;
        logic signed [DEPTH_BITS-1:0] z;
        n = 0;
        iter = 0;
        hx = (cur_w == 0) ? 1 : ((cur_w > 8) ? 8 : int'(cur_w));
        hy = (cur_h == 0) ? 1 : ((cur_h > 8) ? 8 : int'(cur_h));
        while (n < count) begin
            if (iter % 50 == 0) begin
                send_gaps = ($urandom_range(0, 3) != 0);
                take_stalls = ($urandom_range(0, 3) != 0);
            end
            iter++;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                op = OP_WRITE;
            end else if (pick < 78) begin
                op = OP_READ;
            end else if (pick < 94) begin
                op = OP_CLEAR;
            end else begin
                op = OP_NOP;
            end
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                // small hot region so pixels are hit again and again
                x = COORD_W'($urandom_range(0, hx - 1));
                y = COORD_W'($urandom_range(0, hy - 1));
            end else if (pick == 6 && cur_w != 0 && cur_h != 0) begin
                x = COORD_W'($urandom_range(0, int'(cur_w) - 1));
                y = COORD_W'($urandom_range(0, int'(cur_h) - 1));
            end else if (pick == 7) begin
                x = COORD_W'(($urandom_range(0, 2) == 0) ? -1
                             : int'(cur_w) - 1 + int'($urandom_range(0, 1)));
                y = COORD_W'(($urandom_range(0, 2) == 0) ? -1
                             : int'(cur_h) - 1 + int'($urandom_range(0, 1)));
            end else begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            pick = $urandom_range(0, 19);
            if (pick <= 2) begin
                z = DEPTH_BITS'(($urandom_range(0, 1) ? cur_near : cur_far)
                                + (int'($urandom_range(0, 2)) - 1));
            end else if (pick <= 11) begin
                z = DEPTH_BITS'(int'($urandom_range(0, 64)) - 32);
            end else begin
                z = DEPTH_BITS'($urandom);
            end
            send_frag(op, x, y, z, $urandom);
            if (op != OP_NOP) n++;
        end
    endtask

    initial begin
        int stall;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = take_stalls ? $urandom_range(0, 12) : 0;
            @(negedge clk);
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (frag_if.valid && frag_if.ready) || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d results still due",
                     quiet_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        frag_if.valid = 1'b0;
        frag_if.op = '0;
        frag_if.pixel_x = '0;
        frag_if.pixel_y = '0;
        frag_if.depth = '0;
        frag_if.frag_color = '0;
        quiet_cycles = 0;
        sent = 0;
        settings_used = 1;
        send_gaps = 1'b1;
        take_stalls = 1'b1;
        cur_w = WIDTH_RST;
        cur_h = HEIGHT_RST;
        cur_near = NEAR_RST;
        cur_far = FAR_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset contents, strict depth test, clears, off-screen, unused op
        send_frag(OP_READ, 0, 0, 0, 32'h0);
        send_frag(OP_WRITE, 0, 0, 100, 32'h1234_5600);
        send_frag(OP_READ, 0, 0, 0, 32'h0);
        send_frag(OP_WRITE, 0, 0, 100, 32'hdead_be00);
        send_frag(OP_WRITE, 0, 0, 101, 32'hdead_be01);
        send_frag(OP_WRITE, 0, 0, 99, 32'habcd_ef00);
        send_frag(OP_WRITE, 5, 5, 24'h7f_ffff, 32'hffff_ff00);
        send_frag(OP_WRITE, 319, 239, 24'h80_0000, 32'hffff_ffff);
        send_frag(OP_READ, 319, 239, 0, 32'h0);
        send_frag(OP_CLEAR, 319, 239, 0, 32'h0);
        send_frag(OP_READ, 319, 239, 0, 32'h0);
        send_frag(OP_WRITE, 320, 0, 0, 32'h5555_5555);
        send_frag(OP_READ, -1, 0, 0, 32'h0);
        send_frag(OP_CLEAR, 0, 240, 0, 32'h0);
        send_frag(OP_WRITE, 12'h800, 12'h7ff, 0, 32'haaaa_aaaa);
        send_frag(OP_READ, 12'h7ff, 12'h800, 0, 32'h0);
        send_frag(OP_NOP, 0, 0, 24'h80_0000, 32'h0);
        send_frag(OP_NOP, -1, -1, 0, 32'h0);
        send_frag(OP_READ, 0, 0, 0, 32'h0);
        drain();

        // near and far bounds
        set_frame(320, 240, 1'b1, -16, 16);
        send_frag(OP_WRITE, 1, 1, -16, 32'h0102_0300);
        send_frag(OP_WRITE, 1, 1, 17, 32'h0102_0301);
        send_frag(OP_WRITE, 1, 1, 16, 32'h0102_0302);
        send_frag(OP_WRITE, 1, 1, -15, 32'h0102_0303);
        send_frag(OP_WRITE, 2, 2, 24'h80_0000, 32'h0102_0304);
        send_frag(OP_READ, 1, 1, 0, 32'h0);
        drain();

        set_frame(320, 240, 1'b0, 0, 24'h7f_ffff);
        send_random(300);
        drain();
        set_frame(1024, 1024, 1'b1, -20, 20);
        send_random(300);
        drain();
        set_frame(1, 1, 1'b1, 24'h80_0000, 24'h7f_ffff);
        send_random(250);
        drain();
        set_frame(0, 7, 1'b0, 0, 0);
        send_random(60);
        drain();
        set_frame(2047, 2047, 1'b0, 24'h7f_ffff, 24'h80_0000);
        send_random(300);
        drain();
        set_frame(13, 5, 1'b1, DEPTH_BITS'(-int'($urandom_range(0, 100))),
                  DEPTH_BITS'($urandom_range(0, 100)));
        send_random(300);
        drain();
        // empty depth window and no rows
        set_frame(9, 0, 1'b1, 24'h7f_ffff, 24'h80_0000);
        send_random(60);
        drain();

        $display("covered %0d fragments under %0d frame and depth-range settings, %0d results compared",
                 sent, settings_used, checked);
        $display("frames ranged from zero size to beyond the store, clip bounds at both extremes");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
